// File: sv/itoa_pkg.sv
// Shared constants, types and helper functions of the integer-to-ASCII formatter.
// Used by itoa_conv, itoa_emit, the top level and the checker; depends on nothing.
package itoa_pkg;

  localparam int VALUE_BITS = 32;

  function automatic int dec_digits(int bits);
    longint unsigned m;
    int n;
    m = (longint'(1) << bits) - 1;
    n = 0;
    while (m != 0) begin
      m = m / 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  // The BCD field is wide enough to hold the octal and hex digit fields as well.
  localparam int DIG_W      = 4 * DEC_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int IN_TDATA_W = ((VALUE_BITS + 1 + 7) / 8) * 8;
  localparam int CHAR_W     = 8;
  localparam int MINW_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int WIDTH_MAX  = 62;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_BIN = 2'd1;
  localparam logic [1:0] BASE_OCT = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  localparam logic [1:0] PLUS_NONE  = 2'd0;
  localparam logic [1:0] PLUS_PLUS  = 2'd1;
  localparam logic [1:0] PLUS_SPACE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_PREFIX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUS_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH   = 3'd5;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

  typedef struct packed {
    logic [1:0]        base_mode;
    logic              upper_case;
    logic              show_prefix;
    logic              zero_pad;
    logic [1:0]        plus_mode;
    logic [MINW_W-1:0] min_width;
  } cfg_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic             neg;
    logic [CNT_W-1:0] nd;
    logic [3:0]       top;
  } conv_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d, logic upper);
    logic [CHAR_W-1:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'b0000, d};
    end else begin
      r = (upper ? CH_UA : CH_LA) + {4'b0000, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

// File: sv/integer_to_ascii_formatter_core.sv
// Integer-to-ASCII formatter top level: configuration registers, digit engine
// and character sequencer. Depends on itoa_pkg, itoa_conv and itoa_emit.
// In decimal a word passes through double-dabble conversion, leading-zero scan and setup
// before the first character; other bases skip the conversion. Then one character per cycle
// while out_tready is high; the next word is taken at the edge after the final
// character enters the output stage. rst_n is synchronous and restores the defaults.
module integer_to_ascii_formatter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] value, [32] is_signed, upper bits zero
  input  logic [itoa_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_char
  output logic [itoa_pkg::CHAR_W-1:0]      out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [itoa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [itoa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import itoa_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  conv_stat_t stat;
  logic       pop;
  logic       start;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_MODE:   cfg_nxt.base_mode   = cfg_wdata[1:0];
        CFG_UPPER_CASE:  cfg_nxt.upper_case  = cfg_wdata[0];
        CFG_SHOW_PREFIX: cfg_nxt.show_prefix = cfg_wdata[0];
        CFG_ZERO_PAD:    cfg_nxt.zero_pad    = cfg_wdata[0];
        CFG_PLUS_MODE:   cfg_nxt.plus_mode   = cfg_wdata[1:0];
        CFG_MIN_WIDTH:   cfg_nxt.min_width   = cfg_wdata[MINW_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_mode   <= BASE_DEC;
      cfg_r.upper_case  <= 1'b0;
      cfg_r.show_prefix <= 1'b0;
      cfg_r.zero_pad    <= 1'b0;
      cfg_r.plus_mode   <= PLUS_NONE;
      cfg_r.min_width   <= MINW_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = stat.idle;
  assign start     = in_tvalid && stat.idle;

  itoa_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .base_mode (cfg_r.base_mode),
    .start     (start),
    .value     (in_tdata[VALUE_BITS-1:0]),
    .is_signed (in_tdata[VALUE_BITS]),
    .pop       (pop),
    .stat      (stat)
  );

  itoa_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .stat      (stat),
    .pop       (pop),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

endmodule

// File: sv/itoa_conv.sv
// Digit engine: bit-serial double-dabble for decimal, leading-zero scan and
// a digit shift register that hands out one digit per pop. Depends on itoa_pkg.
module itoa_conv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     base_mode,
  input  logic                           start,
  input  logic [itoa_pkg::VALUE_BITS-1:0] value,
  input  logic                           is_signed,
  input  logic                           pop,
  output itoa_pkg::conv_stat_t           stat
);
  import itoa_pkg::*;

  localparam logic [1:0] C_IDLE   = 2'd0;
  localparam logic [1:0] C_DABBLE = 2'd1;
  localparam logic [1:0] C_SCAN   = 2'd2;
  localparam logic [1:0] C_DONE   = 2'd3;

  localparam int SH_BIN = DIG_W - VALUE_BITS;
  localparam int SH_OCT = DIG_W - 3 * OCT_DIGITS;
  localparam int SH_HEX = DIG_W - 4 * HEX_DIGITS;

  logic [1:0]            state_r, state_nxt;
  logic [DIG_W-1:0]      dig_r, dig_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;

  logic [3:0]            top;
  logic [DIG_W-1:0]      dig_shift;
  logic [DIG_W-1:0]      adj;
  logic [DIG_W-1:0]      vz;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg_c;

  always_comb begin
    unique case (base_mode)
      BASE_BIN: begin
        top       = {3'b000, dig_r[DIG_W-1]};
        dig_shift = dig_r << 1;
      end
      BASE_OCT: begin
        top       = {1'b0, dig_r[DIG_W-1 -: 3]};
        dig_shift = dig_r << 3;
      end
      default: begin
        top       = dig_r[DIG_W-1 -: 4];
        dig_shift = dig_r << 4;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      adj[4*k +: 4] = (dig_r[4*k +: 4] >= 4'd5) ? dig_r[4*k +: 4] + 4'd3 : dig_r[4*k +: 4];
    end
  end

  assign vz    = DIG_W'(value);
  assign neg_c = is_signed & value[VALUE_BITS-1] & (base_mode == BASE_DEC);
  assign mag   = neg_c ? VALUE_BITS'(~value) + VALUE_BITS'(1) : value;

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          neg_nxt = neg_c;
          unique case (base_mode)
            BASE_DEC: begin
              bin_nxt   = mag;
              dig_nxt   = '0;
              cnt_nxt   = CNT_W'(VALUE_BITS);
              state_nxt = C_DABBLE;
            end
            BASE_BIN: begin
              dig_nxt   = vz << SH_BIN;
              cnt_nxt   = CNT_W'(VALUE_BITS);
              state_nxt = C_SCAN;
            end
            BASE_OCT: begin
              dig_nxt   = vz << SH_OCT;
              cnt_nxt   = CNT_W'(OCT_DIGITS);
              state_nxt = C_SCAN;
            end
            default: begin
              dig_nxt   = vz << SH_HEX;
              cnt_nxt   = CNT_W'(HEX_DIGITS);
              state_nxt = C_SCAN;
            end
          endcase
        end
      end
      C_DABBLE: begin
        {dig_nxt, bin_nxt} = {adj[DIG_W-2:0], bin_r, 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt   = CNT_W'(DEC_DIGITS);
          state_nxt = C_SCAN;
        end
      end
      C_SCAN: begin
        if (top == 4'd0 && cnt_r > CNT_W'(1)) begin
          dig_nxt = dig_shift;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = C_DONE;
        end
      end
      default: begin
        if (pop) begin
          dig_nxt = dig_shift;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = C_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    bin_r <= bin_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign stat.idle = (state_r == C_IDLE);
  assign stat.done = (state_r == C_DONE);
  assign stat.neg  = neg_r;
  assign stat.nd   = cnt_r;
  assign stat.top  = top;

endmodule

// File: sv/itoa_emit.sv
// Character sequencer: prefix, sign, padding and digits, one character per
// cycle while the output is not stalled, into a registered output stage. Depends on itoa_pkg.
module itoa_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  itoa_pkg::cfg_t               cfg,
  input  itoa_pkg::conv_stat_t         stat,
  output logic                         pop,
  output logic [itoa_pkg::CHAR_W-1:0]  out_char,
  output logic                         out_last,
  output logic                         out_valid,
  input  logic                         out_ready
);
  import itoa_pkg::*;

  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_SETUP = 3'd1;
  localparam logic [2:0] E_PRE0  = 3'd2;
  localparam logic [2:0] E_PRE1  = 3'd3;
  localparam logic [2:0] E_SIGNA = 3'd4;
  localparam logic [2:0] E_PAD   = 3'd5;
  localparam logic [2:0] E_SIGNB = 3'd6;
  localparam logic [2:0] E_DIG   = 3'd7;

  logic [2:0]        st_r, st_nxt;
  logic [CHAR_W-1:0] sign_r, sign_nxt;
  logic              has_sign_r, has_sign_nxt;
  logic [MINW_W-1:0] pad_r, pad_nxt;
  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] oc_r, oc_nxt;
  logic              ol_r, ol_nxt;

  logic [MINW_W-1:0] width_sat;
  logic [7:0]        body;
  logic [MINW_W-1:0] pad_c;
  logic              has_sign_c;
  logic [CHAR_W-1:0] sign_c;
  logic              is_dec;
  logic              adv;

  function automatic logic [2:0] after_prefix(logic zp, logic hs, logic pnz);
    logic [2:0] r;
    if (zp) begin
      r = hs ? E_SIGNA : (pnz ? E_PAD : E_DIG);
    end else begin
      r = pnz ? E_PAD : (hs ? E_SIGNB : E_DIG);
    end
    return r;
  endfunction

  assign is_dec    = (cfg.base_mode == BASE_DEC);
  assign width_sat = (cfg.min_width > MINW_W'(WIDTH_MAX)) ? MINW_W'(WIDTH_MAX) : cfg.min_width;

  always_comb begin
    has_sign_c = 1'b0;
    sign_c     = CH_SPACE;
    if (is_dec) begin
      if (stat.neg) begin
        has_sign_c = 1'b1;
        sign_c     = CH_MINUS;
      end else if (cfg.plus_mode == PLUS_PLUS) begin
        has_sign_c = 1'b1;
        sign_c     = CH_PLUS;
      end else if (cfg.plus_mode == PLUS_SPACE) begin
        has_sign_c = 1'b1;
        sign_c     = CH_SPACE;
      end
    end
  end

  assign body  = 8'(stat.nd) + {7'd0, has_sign_c};
  assign pad_c = (8'(width_sat) > body) ? MINW_W'(8'(width_sat) - body) : '0;
  assign adv   = !ov_r || out_ready;

  always_comb begin
    st_nxt       = st_r;
    sign_nxt     = sign_r;
    has_sign_nxt = has_sign_r;
    pad_nxt      = pad_r;
    ov_nxt       = ov_r && !out_ready;
    oc_nxt       = oc_r;
    ol_nxt       = ol_r;
    pop          = 1'b0;
    unique case (st_r)
      E_IDLE: begin
        if (stat.done) begin
          st_nxt = E_SETUP;
        end
      end
      E_SETUP: begin
        sign_nxt     = sign_c;
        has_sign_nxt = has_sign_c;
        pad_nxt      = pad_c;
        if (cfg.show_prefix && !is_dec) begin
          st_nxt = E_PRE0;
        end else begin
          st_nxt = after_prefix(cfg.zero_pad, has_sign_c, pad_c != '0);
        end
      end
      E_PRE0: begin
        if (adv) begin
          ov_nxt = 1'b1;
          oc_nxt = CH_ZERO;
          ol_nxt = 1'b0;
          if (cfg.base_mode == BASE_BIN || cfg.base_mode == BASE_HEX) begin
            st_nxt = E_PRE1;
          end else begin
            st_nxt = after_prefix(cfg.zero_pad, has_sign_r, pad_r != '0);
          end
        end
      end
      E_PRE1: begin
        if (adv) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b0;
          if (cfg.base_mode == BASE_BIN) begin
            oc_nxt = cfg.upper_case ? CH_UB : CH_LB;
          end else begin
            oc_nxt = cfg.upper_case ? CH_UX : CH_LX;
          end
          st_nxt = after_prefix(cfg.zero_pad, has_sign_r, pad_r != '0);
        end
      end
      E_SIGNA: begin
        if (adv) begin
          ov_nxt = 1'b1;
          oc_nxt = sign_r;
          ol_nxt = 1'b0;
          st_nxt = (pad_r != '0) ? E_PAD : E_DIG;
        end
      end
      E_PAD: begin
        if (adv) begin
          ov_nxt  = 1'b1;
          oc_nxt  = cfg.zero_pad ? CH_ZERO : CH_SPACE;
          ol_nxt  = 1'b0;
          pad_nxt = pad_r - MINW_W'(1);
          if (pad_r == MINW_W'(1)) begin
            st_nxt = (!cfg.zero_pad && has_sign_r) ? E_SIGNB : E_DIG;
          end
        end
      end
      E_SIGNB: begin
        if (adv) begin
          ov_nxt = 1'b1;
          oc_nxt = sign_r;
          ol_nxt = 1'b0;
          st_nxt = E_DIG;
        end
      end
      default: begin
        if (adv) begin
          pop    = 1'b1;
          ov_nxt = 1'b1;
          oc_nxt = digit_char(stat.top, cfg.upper_case);
          ol_nxt = (stat.nd == CNT_W'(1));
          if (stat.nd == CNT_W'(1)) begin
            st_nxt = E_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_r     <= sign_nxt;
    has_sign_r <= has_sign_nxt;
    pad_r      <= pad_nxt;
    oc_r       <= oc_nxt;
    ol_r       <= ol_nxt;
  end

  assign out_char  = oc_r;
  assign out_last  = ol_r;
  assign out_valid = ov_r;

endmodule

// File: sv/itoa_checker.sv
// Port-level checks for the integer-to-ASCII formatter and the bind that
// attaches them to the top level. Depends on itoa_pkg.
module itoa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [itoa_pkg::CHAR_W-1:0]      out_tdata,
  input logic                             out_tlast
);
  import itoa_pkg::*;

  // A stalled word holds its character and end marker.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Once a number is taken, no further number is taken in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // Characters of one number follow each other without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a number's text");

  // While a number's text is still pending, no new number is taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready before the final character");

endmodule

bind integer_to_ascii_formatter_core itoa_checker u_itoa_checker (.*);
